// ===== rtl/mds_b_matrix_accumulator_defines.svh =====
// Assertion macros used by the top-level accumulator RTL.
`ifndef MDS_B_MATRIX_ACCUMULATOR_DEFINES_SVH
`define MDS_B_MATRIX_ACCUMULATOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Check a property on every rising edge, quiet while reset is active.
`define MBA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on every rising edge, reset included.
`define MBA_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MBA_ASSERT(label, clk, rst_n, prop, msg)
`define MBA_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== rtl/mba_pkg.sv =====
package mba_pkg;

    localparam int ENTRY_W = 48;
    localparam int IDX_W   = 6;
    localparam int SIZE_W  = 7;
    localparam int VAL_W   = 32;
    localparam int DELTA_W = VAL_W + 1;
    localparam int NUM_W   = VAL_W + 16;
    localparam int DEN_W   = VAL_W + SIZE_W;

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

    localparam logic signed [ENTRY_W-1:0] ENTRY_MAX = {1'b0, {(ENTRY_W-1){1'b1}}};
    localparam logic signed [ENTRY_W-1:0] ENTRY_MIN = {1'b1, {(ENTRY_W-1){1'b0}}};

    typedef struct packed {
        logic [1:0]       command;
        logic [IDX_W-1:0] row_index;
        logic [IDX_W-1:0] col_index;
        logic [VAL_W-1:0] target_dissimilarity;
        logic [VAL_W-1:0] current_distance;
    } t_cmd_item;

    typedef struct packed {
        logic signed [ENTRY_W-1:0] entry_value;
        logic                      overflow_seen;
    } t_result_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_ACCUM,
        ST_ZERO
    } t_st_op;

    typedef struct packed {
        t_st_op                    op;
        logic signed [DELTA_W-1:0] delta;
    } t_store_req;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_UPD_RD,
        S_UPD_WR,
        S_RESP
    } t_state;

endpackage

// ===== rtl/mba_divider.sv =====
module mba_divider
    import mba_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [VAL_W-1:0]  i_dividend,
    input  logic [VAL_W-1:0]  i_distance,
    input  logic [SIZE_W-1:0] i_size,
    output logic              o_done,
    output logic [NUM_W-1:0]  o_quotient
);

    localparam int CNT_W = $clog2(NUM_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NUM_W - 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;
    logic [NUM_W-1:0] r_quo;

    logic [DEN_W:0]   rem_sh;
    logic             take;
    logic [DEN_W:0]   rem_sub;

    // One quotient bit per cycle, restoring form.
    always_comb begin
        rem_sh  = {r_rem, r_quo[NUM_W-1]};
        take    = rem_sh >= {1'b0, r_den};
        rem_sub = rem_sh - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= DEN_W'(i_distance) * DEN_W'(i_size);
            r_rem <= '0;
            r_quo <= {i_dividend, 16'd0};
        end else if (r_busy) begin
            r_rem <= take ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], take};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== rtl/mba_store.sv =====
module mba_store
    import mba_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic                      i_clk,
    input  t_store_req                i_req,
    input  logic [AW-1:0]             i_addr,
    output logic signed [ENTRY_W-1:0] o_rdata,
    output logic                      o_sat
);

    logic signed [ENTRY_W-1:0] r_mem [DEPTH];
    logic signed [ENTRY_W-1:0] r_rdata;

    logic signed [ENTRY_W:0]   sum;
    logic                      ovf;
    logic signed [ENTRY_W-1:0] wval;

    // Saturating add of the delta onto the entry read in the previous cycle.
    always_comb begin
        sum  = {r_rdata[ENTRY_W-1], r_rdata}
             + {{(ENTRY_W + 1 - DELTA_W){i_req.delta[DELTA_W-1]}}, i_req.delta};
        ovf  = sum[ENTRY_W] ^ sum[ENTRY_W-1];
        wval = ovf ? (sum[ENTRY_W] ? ENTRY_MIN : ENTRY_MAX) : sum[ENTRY_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        case (i_req.op)
            ST_READ:  r_rdata <= r_mem[i_addr];
            ST_ACCUM: r_mem[i_addr] <= wval;
            ST_ZERO:  r_mem[i_addr] <= '0;
            default:  ;
        endcase
    end

    assign o_rdata = r_rdata;
    assign o_sat   = (i_req.op == ST_ACCUM) && ovf;

endmodule

// ===== rtl/mds_b_matrix_accumulator.sv =====
// Channel   | Direction | Handshake                | Payload
// ----------+-----------+--------------------------+----------------------------
// command   | in        | start high, busy low     | i_cmd (t_cmd_item)
// result    | out       | o_result_valid, 1 cycle  | o_result (t_result_item)
// config    | in/out    | APB, write when psel &   | paddr, pwdata, prdata
//           |           | penable & pwrite & pready|
//
// Add with nonzero distance: the 48-step divider runs first (a multiply
// step, 48 quotient bits, a done step), then four read-modify-write
// updates follow on the single store port, each a read then a write.
// Read: the entry is read from the store and shown as the result. Ignored
// add, zero-distance add, unused command: no store access, no result.
// After reset and on a clear command, a pass over all MAX_POINTS*MAX_POINTS
// entries (4096 at the default) zeroes the store; busy stays high during it.
// The receiver cannot stall: each result shows for exactly one cycle.
`include "mds_b_matrix_accumulator_defines.svh"
module mds_b_matrix_accumulator
    import mba_pkg::*;
#(
    parameter int MAX_POINTS = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         start,
    output logic         busy,
    input  t_cmd_item    i_cmd,
    output logic         o_result_valid,
    output t_result_item o_result,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int DEPTH = MAX_POINTS * MAX_POINTS;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    t_state r_state, n_state;

    logic [SIZE_W-1:0] r_size;
    logic              r_flag;
    logic [AW-1:0]     r_clr_addr;
    logic [IDX_W-1:0]  r_row;
    logic [IDX_W-1:0]  r_col;
    logic              r_oob;
    logic [1:0]        r_upd_idx;
    logic [VAL_W-1:0]  r_cell;

    logic                      accept;
    logic                      add_ok;
    logic                      in_store;
    logic                      div_start;
    logic                      div_done;
    logic [NUM_W-1:0]          div_quo;
    logic                      quo_big;
    t_store_req                st_req;
    logic [AW-1:0]             st_addr;
    logic signed [ENTRY_W-1:0] st_rdata;
    logic                      st_sat;
    logic [IDX_W-1:0]          upd_row;
    logic [IDX_W-1:0]          upd_col;
    logic signed [DELTA_W-1:0] cell_ext;

    function automatic logic [AW-1:0] f_addr(input logic [IDX_W-1:0] row,
                                             input logic [IDX_W-1:0] col);
        return AW'(32'(row) * MAX_POINTS + 32'(col));
    endfunction

    // Configuration port: one register, size_in_use, at byte address 0.
    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {{(32 - SIZE_W){1'b0}}, r_size};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_RESET;
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            r_size <= pwdata[SIZE_W-1:0];
        end
    end

    assign accept = start && !busy;

    // An add touches the store only for a distinct in-range pair with a nonzero
    // distance; a zero-distance add is ignored and leaves every entry as it is.
    always_comb begin
        in_store = (32'(i_cmd.row_index) < MAX_POINTS)
                && (32'(i_cmd.col_index) < MAX_POINTS);
        add_ok   = in_store
                && ({1'b0, i_cmd.row_index} < r_size)
                && ({1'b0, i_cmd.col_index} < r_size)
                && (i_cmd.row_index != i_cmd.col_index)
                && (i_cmd.current_distance != '0);
    end

    // Update order: (i,j) and (j,i) lose the cell, (i,i) and (j,j) gain it.
    always_comb begin
        upd_row  = r_upd_idx[0] ? r_col : r_row;
        upd_col  = (r_upd_idx == 2'd0 || r_upd_idx == 2'd3) ? r_col : r_row;
        cell_ext = {1'b0, r_cell};
        quo_big  = div_quo[NUM_W-1:VAL_W] != '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        busy           = 1'b1;
        div_start      = 1'b0;
        o_result_valid = 1'b0;
        st_req.op      = ST_IDLE;
        st_req.delta   = '0;
        st_addr        = f_addr(upd_row, upd_col);
        unique case (r_state)
            S_CLEAR: begin
                st_req.op = ST_ZERO;
                st_addr   = r_clr_addr;
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                busy    = 1'b0;
                st_addr = f_addr(i_cmd.row_index, i_cmd.col_index);
                if (accept) begin
                    unique case (i_cmd.command)
                        CMD_CLEAR: n_state = S_CLEAR;
                        CMD_READ: begin
                            st_req.op = ST_READ;
                            n_state   = S_RESP;
                        end
                        CMD_ADD: begin
                            if (add_ok) begin
                                div_start = 1'b1;
                                n_state   = S_DIV;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_UPD_RD;
                end
            end
            S_UPD_RD: begin
                st_req.op = ST_READ;
                n_state   = S_UPD_WR;
            end
            S_UPD_WR: begin
                st_req.op    = ST_ACCUM;
                st_req.delta = r_upd_idx[1] ? cell_ext : -cell_ext;
                n_state      = (r_upd_idx == 2'd3) ? S_IDLE : S_UPD_RD;
            end
            S_RESP: begin
                o_result_valid = 1'b1;
                n_state        = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sticky flag: drop on reset and clear, set on any saturation.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag <= 1'b0;
        end else if (accept && i_cmd.command == CMD_CLEAR) begin
            r_flag <= 1'b0;
        end else if ((r_state == S_DIV && div_done && quo_big) || st_sat) begin
            r_flag <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_upd_idx  <= '0;
        end else begin
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end else begin
                r_clr_addr <= '0;
            end
            if (r_state == S_UPD_WR) begin
                r_upd_idx <= r_upd_idx + 1'b1;
            end else if (r_state == S_IDLE) begin
                r_upd_idx <= '0;
            end
        end
    end

    // Hold the pair and the read range check for the rest of the item.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_row <= i_cmd.row_index;
            r_col <= i_cmd.col_index;
            r_oob <= !in_store;
        end
        if (r_state == S_DIV && div_done) begin
            r_cell <= quo_big ? {VAL_W{1'b1}} : div_quo[VAL_W-1:0];
        end
    end

    assign o_result.entry_value   = r_oob ? '0 : st_rdata;
    assign o_result.overflow_seen = r_flag;

    mba_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_cmd.target_dissimilarity),
        .i_distance (i_cmd.current_distance),
        .i_size     (r_size),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    mba_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_req   (st_req),
        .i_addr  (st_addr),
        .o_rdata (st_rdata),
        .o_sat   (st_sat)
    );

    `MBA_ASSERT(a_rmw_same_addr, i_clk, i_rst_n, (r_state == S_UPD_WR) |-> (st_addr == $past(st_addr)), "update write address differs from its read")
    `MBA_ASSERT(a_pair_distinct, i_clk, i_rst_n, (r_state == S_UPD_RD) |-> (r_row != r_col), "store update for an equal-index pair")
    `MBA_ASSERT(a_div_done_state, i_clk, i_rst_n, div_done |-> (r_state == S_DIV), "divider finished outside the divide phase")
    `MBA_ASSERT(a_result_pulse, i_clk, i_rst_n, o_result_valid |=> !o_result_valid, "result strobe held longer than one cycle")

endmodule
